/* rtl/core/cvm_pkg.sv */
// shared constants for the camera view matrix core
`timescale 1ns / 1ps
`default_nettype none

package cvm_pkg;

    localparam int COORD_W = 32;   // input and shift field width
    localparam int BASIS_W = 18;   // basis component width
    localparam int FRAC_W  = 16;   // fraction bits of q16.16
    localparam int NORM_W  = 31;   // normalized magnitude width
    localparam int NORM_MSB = 30;  // the largest normalized magnitude lands in [2^30, 2^31)
    localparam int ROOT_W  = 32;   // integer square root of a 64 bit sum
    localparam int SUMSQ_W = 64;
    localparam int QUOT_W  = 17;   // unit component magnitude, at most 65536
    localparam int Q_ONE   = 65536;
    localparam int CROSS_W = 50;   // cross product of unit look and raw right

endpackage

`default_nettype wire

/* rtl/core/cvm_norm.sv */
// pipelined vector normalizer: scale, sum of squares, square root, divide
`timescale 1ns / 1ps
`default_nettype none

module cvm_norm #(
    parameter int VW = 32,
    parameter int SW = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_valid,
    input  wire logic [2:0][VW-1:0]   i_v,
    input  wire logic [SW-1:0]        i_side,
    output logic                      o_valid,
    output logic [2:0][cvm_pkg::BASIS_W-1:0] o_u,
    output logic [SW-1:0]             o_side
);

    localparam int PW  = $clog2(VW);
    localparam int NW  = cvm_pkg::NORM_W;
    localparam int RW  = cvm_pkg::ROOT_W;
    localparam int SQW = cvm_pkg::SUMSQ_W;
    localparam int QW  = cvm_pkg::QUOT_W;
    localparam int BW  = cvm_pkg::BASIS_W;
    localparam int NUM_W = NW + QW + 1;     // numerator m*2^17 + L
    localparam int DEN_W = RW + 1;          // denominator 2L
    localparam int CW  = 3 * NW + 3 + 1 + SW;
    localparam int DCW = 3 + 1 + SW;

    // stage 1: magnitudes
    logic              r1_v;
    logic [2:0][VW-1:0] r1_m;
    logic [2:0]        r1_sgn;
    logic [VW-1:0]     r1_or;
    logic [SW-1:0]     r1_side;

    // stage 2: leading one position
    logic              r2_v;
    logic [2:0][VW-1:0] r2_m;
    logic [2:0]        r2_sgn;
    logic [PW-1:0]     r2_pos;
    logic              r2_zero;
    logic [SW-1:0]     r2_side;

    // stage 3: scaled magnitudes
    logic              r3_v;
    logic [2:0][NW-1:0] r3_nm;
    logic [2:0]        r3_sgn;
    logic              r3_zero;
    logic [SW-1:0]     r3_side;

    // stage 4: squares
    logic              r4_v;
    logic [2:0][2*NW-1:0] r4_sq;
    logic [CW-1:0]     r4_c;

    // square root stages
    logic              r_sq_v   [0:RW];
    logic [SQW-1:0]    r_sq_rem [0:RW];
    logic [RW-1:0]     r_sq_root[0:RW];
    logic [CW-1:0]     r_sq_c   [0:RW];

    // divide stages
    logic              r_dv_v   [0:QW];
    logic [NUM_W-1:0]  r_dv_rem [0:QW][0:2];
    logic [QW-1:0]     r_dv_q   [0:QW][0:2];
    logic [DEN_W-1:0]  r_dv_den [0:QW];
    logic [DCW-1:0]    r_dv_c   [0:QW];

    logic              r_o_v;
    logic [2:0][BW-1:0] r_o_u;
    logic [SW-1:0]     r_o_side;

    logic [2:0][VW-1:0] n_m;
    logic [PW-1:0]     n_pos;
    logic [2:0][NW-1:0] n_nm;
    logic [VW+NW-1:0]  w_ext;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_m[j] = i_v[j][VW-1] ? (~i_v[j] + VW'(1)) : i_v[j];
        end
    end

    always_comb begin
        n_pos = '0;
        for (int b = 0; b < VW; b++) begin
            if (r1_or[b]) n_pos = PW'(b);
        end
    end

    always_comb begin
        w_ext = '0;
        for (int j = 0; j < 3; j++) begin
            w_ext = {{NW{1'b0}}, r2_m[j]};
            if (r2_pos >= PW'(cvm_pkg::NORM_MSB)) begin
                w_ext = w_ext >> (r2_pos - PW'(cvm_pkg::NORM_MSB));
            end else begin
                w_ext = w_ext << (PW'(cvm_pkg::NORM_MSB) - r2_pos);
            end
            n_nm[j] = w_ext[NW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r_sq_v[0] <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r_sq_v[0] <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_m    <= n_m;
            r1_or   <= n_m[0] | n_m[1] | n_m[2];
            for (int j = 0; j < 3; j++) r1_sgn[j] <= i_v[j][VW-1];
            r1_side <= i_side;

            r2_m    <= r1_m;
            r2_sgn  <= r1_sgn;
            r2_pos  <= n_pos;
            r2_zero <= (r1_or == '0);
            r2_side <= r1_side;

            r3_nm   <= n_nm;
            r3_sgn  <= r2_sgn;
            r3_zero <= r2_zero;
            r3_side <= r2_side;

            for (int j = 0; j < 3; j++) r4_sq[j] <= r3_nm[j] * r3_nm[j];
            r4_c <= {r3_side, r3_zero, r3_sgn, r3_nm};

            r_sq_rem[0]  <= SQW'(r4_sq[0]) + SQW'(r4_sq[1]) + SQW'(r4_sq[2]);
            r_sq_root[0] <= '0;
            r_sq_c[0]    <= r4_c;
        end
    end

    // one root bit per stage, most significant first
    for (genvar gi = 0; gi < RW; gi++) begin : g_sqrt
        localparam int K = RW - 1 - gi;
        logic [SQW+1:0] w_t;
        logic           w_ge;

        assign w_t  = ({{(SQW+2-RW){1'b0}}, r_sq_root[gi]} << (K + 1))
                    | ((SQW+2)'(1) << (2 * K));
        assign w_ge = {2'b00, r_sq_rem[gi]} >= w_t;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[gi+1] <= 1'b0;
            end else if (i_en) begin
                r_sq_v[gi+1] <= r_sq_v[gi];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq_rem[gi+1]  <= w_ge ? r_sq_rem[gi] - w_t[SQW-1:0] : r_sq_rem[gi];
                r_sq_root[gi+1] <= w_ge ? (r_sq_root[gi] | (RW'(1) << K)) : r_sq_root[gi];
                r_sq_c[gi+1]    <= r_sq_c[gi];
            end
        end
    end

    // divide setup: numerator m*2^17 + L, denominator 2L
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else if (i_en) begin
            r_dv_v[0] <= r_sq_v[RW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                r_dv_rem[0][j] <= {1'b0, r_sq_c[RW][j*NW +: NW], {QW{1'b0}}}
                                + NUM_W'(r_sq_root[RW]);
                r_dv_q[0][j]   <= '0;
            end
            r_dv_den[0] <= {r_sq_root[RW], 1'b0};
            r_dv_c[0]   <= r_sq_c[RW][CW-1 -: DCW];
        end
    end

    for (genvar gi = 0; gi < QW; gi++) begin : g_div
        localparam int K = QW - 1 - gi;
        logic [NUM_W:0] w_t;

        assign w_t = {{(NUM_W+1-DEN_W){1'b0}}, r_dv_den[gi]} << K;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[gi+1] <= 1'b0;
            end else if (i_en) begin
                r_dv_v[gi+1] <= r_dv_v[gi];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int j = 0; j < 3; j++) begin
                    if ({1'b0, r_dv_rem[gi][j]} >= w_t) begin
                        r_dv_rem[gi+1][j] <= r_dv_rem[gi][j] - w_t[NUM_W-1:0];
                        r_dv_q[gi+1][j]   <= r_dv_q[gi][j] | (QW'(1) << K);
                    end else begin
                        r_dv_rem[gi+1][j] <= r_dv_rem[gi][j];
                        r_dv_q[gi+1][j]   <= r_dv_q[gi][j];
                    end
                end
                r_dv_den[gi+1] <= r_dv_den[gi];
                r_dv_c[gi+1]   <= r_dv_c[gi];
            end
        end
    end

    // sign restore, zero length gives zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (i_en) begin
            r_o_v <= r_dv_v[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                if (r_dv_c[QW][3]) begin
                    r_o_u[j] <= '0;
                end else if (r_dv_c[QW][j]) begin
                    r_o_u[j] <= BW'(0) - BW'(r_dv_q[QW][j]);
                end else begin
                    r_o_u[j] <= BW'(r_dv_q[QW][j]);
                end
            end
            r_o_side <= r_dv_c[QW][DCW-1 -: SW];
        end
    end

    assign o_valid = r_o_v;
    assign o_u     = r_o_u;
    assign o_side  = r_o_side;

endmodule

`default_nettype wire

/* rtl/core/camera_view_matrix_core.sv */
// camera view matrix core: orthonormal basis and translation from right, look, position
//
// slave stream takes one camera per beat: right, look and position vectors in
// signed q16.16. master stream gives one beat per camera: the orthonormal
// right, up and look vectors (18 bit signed q2.16) and the three translation terms
// (32 bit q16.16, saturated).
// while the output is not stalled, a new beat is accepted every cycle: two
// chained normalizers, each with a 32 stage square root and a 17 stage
// divide, set the depth, and every stage advances together.
// when the receiver holds tready low with a beat on the output, the whole
// pipeline freezes and s_axis tready drops in the same cycle; nothing is lost
// or repeated. reset clears every valid bit, so the output is empty after it.
`timescale 1ns / 1ps
`default_nettype none

module camera_view_matrix_core (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // right_x, right_y, right_z, look_x, look_y, look_z, pos_x, pos_y, pos_z
    input  wire logic [287:0] i_s_axis_tdata,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // basis_right_x/y/z, basis_up_x/y/z, basis_look_x/y/z, shift_x, shift_y,
    // shift_z, 6 zero bits
    output logic [263:0]      o_m_axis_tdata
);

    localparam int CO = cvm_pkg::COORD_W;
    localparam int BW = cvm_pkg::BASIS_W;
    localparam int XW = cvm_pkg::CROSS_W;
    localparam int FW = cvm_pkg::FRAC_W;
    localparam int S1W = 6 * CO;            // raw right and position
    localparam int S2W = 3 * BW + 3 * CO;   // unit look and position
    localparam int PRW = 2 * BW;            // basis product
    localparam int RDW = 2 * BW + 1;        // basis product difference
    localparam int DPW = CO + BW;           // position times basis
    localparam int DSW = DPW + 2;           // sum of three
    localparam int CAW = 6 * BW + 3 * CO;   // up, look, position
    localparam int CBW = 9 * BW;            // right, up, look

    logic w_en;

    // normalizer 1: look
    logic                  w_n1_v;
    logic [2:0][BW-1:0]    w_n1_u;
    logic [S1W-1:0]        w_n1_side;
    logic [2:0][CO-1:0]    w_look;

    // cross products
    logic                  r_x1_v;
    logic signed [XW-1:0]  r_x1_p [0:5];
    logic [S2W-1:0]        r_x1_side;
    logic                  r_x2_v;
    logic [2:0][XW-1:0]    r_x2_c;
    logic [S2W-1:0]        r_x2_side;

    // normalizer 2: up
    logic                  w_n2_v;
    logic [2:0][BW-1:0]    w_n2_u;
    logic [S2W-1:0]        w_n2_side;

    // right re-forming
    logic                  r_r1_v;
    logic signed [PRW-1:0] r_r1_p [0:5];
    logic [CAW-1:0]        r_r1_c;
    logic                  r_r2_v;
    logic signed [RDW-1:0] r_r2_d [0:2];
    logic [CAW-1:0]        r_r2_c;
    logic                  r_r3_v;
    logic [2:0][BW-1:0]    r_r3_r;
    logic [CAW-1:0]        r_r3_c;

    // translation
    logic                  r_d1_v;
    logic signed [DPW-1:0] r_d1_p [0:8];
    logic [CBW-1:0]        r_d1_c;
    logic                  r_d2_v;
    logic signed [DSW-1:0] r_d2_s [0:2];
    logic [CBW-1:0]        r_d2_c;
    logic                  r_o_v;
    logic [CBW-1:0]        r_o_b;
    logic [2:0][CO-1:0]    r_o_t;

    logic signed [BW-1:0]  w_l [0:2];
    logic signed [CO-1:0]  w_rr [0:2];
    logic signed [BW-1:0]  w_u2 [0:2];
    logic signed [BW-1:0]  w_l2 [0:2];
    logic signed [CO-1:0]  w_pos [0:2];
    logic signed [BW-1:0]  w_bas [0:8];
    logic [2:0][BW-1:0]    n_rr;
    logic [2:0][CO-1:0]    n_t;

    assign w_en = !r_o_v || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    always_comb begin
        for (int j = 0; j < 3; j++) w_look[j] = i_s_axis_tdata[(3 + j) * CO +: CO];
    end

    cvm_norm #(
        .VW (CO),
        .SW (S1W)
    ) u_norm_look (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_axis_tvalid),
        .i_v     (w_look),
        .i_side  ({i_s_axis_tdata[9*CO-1 -: 3*CO], i_s_axis_tdata[3*CO-1:0]}),
        .o_valid (w_n1_v),
        .o_u     (w_n1_u),
        .o_side  (w_n1_side)
    );

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_l[j]  = w_n1_u[j];
            w_rr[j] = w_n1_side[j*CO +: CO];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1_v <= 1'b0;
            r_x2_v <= 1'b0;
            r_r1_v <= 1'b0;
            r_r2_v <= 1'b0;
            r_r3_v <= 1'b0;
            r_d1_v <= 1'b0;
            r_d2_v <= 1'b0;
            r_o_v  <= 1'b0;
        end else if (w_en) begin
            r_x1_v <= w_n1_v;
            r_x2_v <= r_x1_v;
            r_r1_v <= w_n2_v;
            r_r2_v <= r_r1_v;
            r_r3_v <= r_r2_v;
            r_d1_v <= r_r3_v;
            r_d2_v <= r_d1_v;
            r_o_v  <= r_d2_v;
        end
    end

    // look x right
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x1_p[0] <= XW'(w_l[1] * w_rr[2]);
            r_x1_p[1] <= XW'(w_l[2] * w_rr[1]);
            r_x1_p[2] <= XW'(w_l[2] * w_rr[0]);
            r_x1_p[3] <= XW'(w_l[0] * w_rr[2]);
            r_x1_p[4] <= XW'(w_l[0] * w_rr[1]);
            r_x1_p[5] <= XW'(w_l[1] * w_rr[0]);
            r_x1_side <= {w_n1_side[S1W-1 -: 3*CO], w_n1_u};
            for (int j = 0; j < 3; j++) begin
                r_x2_c[j] <= XW'(r_x1_p[2*j] - r_x1_p[2*j+1]);
            end
            r_x2_side <= r_x1_side;
        end
    end

    cvm_norm #(
        .VW (XW),
        .SW (S2W)
    ) u_norm_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_x2_v),
        .i_v     (r_x2_c),
        .i_side  (r_x2_side),
        .o_valid (w_n2_v),
        .o_u     (w_n2_u),
        .o_side  (w_n2_side)
    );

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_u2[j] = w_n2_u[j];
            w_l2[j] = w_n2_side[j*BW +: BW];
        end
    end

    // up x look, rounded and clamped to one
    always_comb begin
        logic signed [RDW-1:0] d;
        logic [RDW-1:0]        mag;
        logic [RDW-FW:0]       q;
        for (int j = 0; j < 3; j++) begin
            d   = r_r2_d[j];
            mag = d[RDW-1] ? RDW'(0) - RDW'(d) : RDW'(d);
            q   = (RDW-FW+1)'(({1'b0, mag} + (RDW+1)'(1 << (FW - 1))) >> FW);
            if (q > (RDW-FW+1)'(cvm_pkg::Q_ONE)) q = (RDW-FW+1)'(cvm_pkg::Q_ONE);
            n_rr[j] = d[RDW-1] ? BW'(0) - BW'(q) : BW'(q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_r1_p[0] <= w_u2[1] * w_l2[2];
            r_r1_p[1] <= w_u2[2] * w_l2[1];
            r_r1_p[2] <= w_u2[2] * w_l2[0];
            r_r1_p[3] <= w_u2[0] * w_l2[2];
            r_r1_p[4] <= w_u2[0] * w_l2[1];
            r_r1_p[5] <= w_u2[1] * w_l2[0];
            r_r1_c    <= {w_n2_side, w_n2_u};
            for (int j = 0; j < 3; j++) begin
                r_r2_d[j] <= RDW'(r_r1_p[2*j]) - RDW'(r_r1_p[2*j+1]);
            end
            r_r2_c <= r_r1_c;
            r_r3_r <= n_rr;
            r_r3_c <= r_r2_c;
        end
    end

    // basis order: right, up, look
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_bas[j]     = r_r3_r[j];
            w_bas[3 + j] = r_r3_c[j*BW +: BW];
            w_bas[6 + j] = r_r3_c[(3 + j)*BW +: BW];
            w_pos[j]     = r_r3_c[6*BW + j*CO +: CO];
        end
    end

    // minus the rounded dot product, saturated
    always_comb begin
        logic signed [DSW-1:0] s;
        logic [DSW-1:0]        mag;
        logic [DSW-FW:0]       q;
        for (int j = 0; j < 3; j++) begin
            s   = r_d2_s[j];
            mag = s[DSW-1] ? DSW'(0) - DSW'(s) : DSW'(s);
            q   = (DSW-FW+1)'(({1'b0, mag} + (DSW+1)'(1 << (FW - 1))) >> FW);
            if (s[DSW-1]) begin
                n_t[j] = (q > (DSW-FW+1)'(32'h7fff_ffff)) ? 32'h7fff_ffff : CO'(q);
            end else begin
                n_t[j] = (q > (DSW-FW+1)'(33'h0_8000_0000)) ? 32'h8000_0000
                                                             : CO'(0) - CO'(q);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    r_d1_p[3*k + j] <= w_pos[j] * w_bas[3*k + j];
                end
            end
            r_d1_c <= {r_r3_c[6*BW-1:0], r_r3_r};
            for (int k = 0; k < 3; k++) begin
                r_d2_s[k] <= DSW'(r_d1_p[3*k]) + DSW'(r_d1_p[3*k+1]) + DSW'(r_d1_p[3*k+2]);
            end
            r_d2_c <= r_d1_c;
            r_o_t  <= n_t;
            r_o_b  <= r_d2_c;
        end
    end

    assign o_m_axis_tvalid = r_o_v;
    assign o_m_axis_tdata  = {6'd0, r_o_t, r_o_b};

endmodule

`default_nettype wire

/* rtl/core/cvm_checker.sv */
// port checks for the camera view matrix core
`timescale 1ns / 1ps
`default_nettype none

module cvm_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         i_s_axis_tvalid,
    input wire logic         o_s_axis_tready,
    input wire logic [287:0] i_s_axis_tdata,
    input wire logic         o_m_axis_tvalid,
    input wire logic         i_m_axis_tready,
    input wire logic [263:0] o_m_axis_tdata
);

    // output empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output beat valid after reset");

    // a stalled output beat holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid
            && $stable(o_m_axis_tdata))
        else $error("stalled output beat changed");

    // the pipeline freezes under output stall, so input tready is low
    a_stall_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |-> !o_s_axis_tready)
        else $error("input taken while pipeline frozen");

    // basis right x stays within one and the six top pad bits are zero
    a_right_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> $signed(o_m_axis_tdata[17:0]) <= 18'sd65536
            && $signed(o_m_axis_tdata[17:0]) >= -18'sd65536
            && o_m_axis_tdata[263:258] == 6'd0)
        else $error("basis right x out of range");

endmodule

bind camera_view_matrix_core cvm_checker u_cvm_checker (.*);

`default_nettype wire

/* tb/testbench.sv */
// stream testbench for the camera view matrix core
`timescale 1ns / 1ps
`default_nettype none

module testbench;

    typedef struct {
        logic signed [cvm_pkg::COORD_W-1:0] rgt [3];
        logic signed [cvm_pkg::COORD_W-1:0] lk [3];
        logic signed [cvm_pkg::COORD_W-1:0] pos [3];
    } t_camera;

    typedef struct {
        logic signed [cvm_pkg::BASIS_W-1:0] rgt [3];
        logic signed [cvm_pkg::BASIS_W-1:0] up [3];
        logic signed [cvm_pkg::BASIS_W-1:0] lk [3];
        logic signed [cvm_pkg::COORD_W-1:0] shift [3];
    } t_view;

    localparam int ITEM_COUNT = 1750;
    localparam int LATENCY    = 120;
    localparam int WATCHDOG   = 20000;
    localparam int HOLD_LEN   = 400;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [287:0] i_s_axis_tdata = '0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [263:0] o_m_axis_tdata;

    camera_view_matrix_core i_dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_view      view_q [$];
    int         mismatch_cnt = 0;
    int         quiet_cycles = 0;
    t_idle_mode idle_mode = IDLE_NONE;
    bit         hold_off = 1'b0;

    // magnitude normalize to q16.16, zero stays zero
    function automatic void unit_vec(input logic signed [63:0] v [3],
                                     output logic signed [63:0] o [3]);
        logic [63:0] m [3];
        logic [63:0] mx, s, root, rem, q, bitv;
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = v[i] < 0 ? -v[i] : v[i];
            if (m[i] > mx) mx = m[i];
        end
        if (mx == 0) begin
            for (int i = 0; i < 3; i++) o[i] = 0;
            return;
        end
        while (mx >= 64'h8000_0000) begin
            for (int i = 0; i < 3; i++) m[i] >>= 1;
            mx >>= 1;
        end
        while (mx < 64'h4000_0000) begin
            for (int i = 0; i < 3; i++) m[i] <<= 1;
            mx <<= 1;
        end
        s = 0;
        for (int i = 0; i < 3; i++) s += m[i] * m[i];
        root = 0;
        rem = s;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv >>= 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << 17) + root) / (root << 1);
            o[i] = v[i] < 0 ? -$signed(q) : $signed(q);
        end
    endfunction

    function automatic logic signed [63:0] round_half(input logic signed [63:0] v);
        logic [63:0] q;
        q = ((v < 0 ? -v : v) + 64'd32768) >> 16;
        return v < 0 ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic signed [cvm_pkg::COORD_W-1:0] shift_term(
            input logic signed [63:0] p [3], input logic signed [63:0] b [3]);
        logic signed [63:0] d;
        d = -round_half(p[0] * b[0] + p[1] * b[1] + p[2] * b[2]);
        if (d > 64'sd2147483647) d = 64'sd2147483647;
        if (d < -64'sd2147483648) d = -64'sd2147483648;
        return d[cvm_pkg::COORD_W-1:0];
    endfunction

    function automatic t_view build_view(input t_camera c);
        logic signed [63:0] rr [3], lr [3], p [3], l [3], x [3], u [3], r [3];
        t_view res;
        for (int i = 0; i < 3; i++) begin
            rr[i] = c.rgt[i];
            lr[i] = c.lk[i];
            p[i]  = c.pos[i];
        end
        unit_vec(lr, l);
        x[0] = l[1] * rr[2] - l[2] * rr[1];
        x[1] = l[2] * rr[0] - l[0] * rr[2];
        x[2] = l[0] * rr[1] - l[1] * rr[0];
        unit_vec(x, u);
        r[0] = u[1] * l[2] - u[2] * l[1];
        r[1] = u[2] * l[0] - u[0] * l[2];
        r[2] = u[0] * l[1] - u[1] * l[0];
        for (int i = 0; i < 3; i++) begin
            r[i] = round_half(r[i]);
            if (r[i] > cvm_pkg::Q_ONE) r[i] = cvm_pkg::Q_ONE;
            if (r[i] < -cvm_pkg::Q_ONE) r[i] = -cvm_pkg::Q_ONE;
            res.rgt[i] = r[i][cvm_pkg::BASIS_W-1:0];
            res.up[i]  = u[i][cvm_pkg::BASIS_W-1:0];
            res.lk[i]  = l[i][cvm_pkg::BASIS_W-1:0];
        end
        res.shift[0] = shift_term(p, r);
        res.shift[1] = shift_term(p, u);
        res.shift[2] = shift_term(p, l);
        return res;
    endfunction

    function automatic logic [287:0] pack_camera(input t_camera c);
        logic [287:0] d;
        for (int i = 0; i < 3; i++) begin
            d[32*i +: 32]     = c.rgt[i];
            d[32*(3+i) +: 32] = c.lk[i];
            d[32*(6+i) +: 32] = c.pos[i];
        end
        return d;
    endfunction

    function automatic t_view unpack_view(input logic [263:0] d);
        t_view v;
        for (int i = 0; i < 3; i++) begin
            v.rgt[i]   = d[18*i +: 18];
            v.up[i]    = d[18*(3+i) +: 18];
            v.lk[i]    = d[18*(6+i) +: 18];
            v.shift[i] = d[162 + 32*i +: 32];
        end
        return v;
    endfunction

    function automatic bit view_eq(input t_view a, input t_view b);
        for (int i = 0; i < 3; i++)
            if (a.rgt[i] !== b.rgt[i] || a.up[i] !== b.up[i] || a.lk[i] !== b.lk[i]
                    || a.shift[i] !== b.shift[i])
                return 0;
        return 1;
    endfunction

    // random coordinate: small, unit-ish or full range
    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $signed($urandom_range(0, 131072)) - 65536;
            2: return $signed($urandom_range(0, 8)) - 4;
            3: return ($urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000);
            4: return $signed($urandom_range(0, 33554432)) - 16777216;
            default: return $signed($urandom_range(0, 4194304)) - 2097152;
        endcase
    endfunction

    // receiver and output check
    always @(posedge i_clk) begin
        t_view got, want;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = unpack_view(o_m_axis_tdata);
                if (view_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected output beat %h", o_m_axis_tdata);
                end else begin
                    want = view_q.pop_front();
                    if (!view_eq(got, want)) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) begin
                            $display({"mismatch: expected r=%0d,%0d,%0d u=%0d,%0d,%0d",
                                      " l=%0d,%0d,%0d s=%0d,%0d,%0d"},
                                want.rgt[0], want.rgt[1], want.rgt[2], want.up[0],
                                want.up[1], want.up[2], want.lk[0], want.lk[1],
                                want.lk[2], want.shift[0], want.shift[1], want.shift[2]);
                            $display({"          actual   r=%0d,%0d,%0d u=%0d,%0d,%0d",
                                      " l=%0d,%0d,%0d s=%0d,%0d,%0d"},
                                got.rgt[0], got.rgt[1], got.rgt[2], got.up[0],
                                got.up[1], got.up[2], got.lk[0], got.lk[1],
                                got.lk[2], got.shift[0], got.shift[1], got.shift[2]);
                        end
                    end
                end
            end
            if (hold_off)
                i_m_axis_tready <= 1'b0;
            else if (idle_mode == IDLE_RECV || idle_mode == IDLE_BOTH)
                i_m_axis_tready <= ($urandom_range(0, 99) >=
                                    (idle_mode == IDLE_RECV ? 83 : 31));
            else
                i_m_axis_tready <= 1'b1;
        end
    end

    // watchdog on cycles with no beat moving
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                || hold_off || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("camera_view_matrix_core: mismatch");
            $finish;
        end
    end

    // long receiver hold-off during the last no-idle phase
    initial begin
        wait (idle_mode == IDLE_SEND);
        wait (idle_mode == IDLE_NONE);
        repeat (50) @(posedge i_clk);
        hold_off = 1'b1;
        repeat (HOLD_LEN) @(posedge i_clk);
        hold_off = 1'b0;
    end

    task automatic send_camera(input t_camera c, input bit directed_known, input t_view known);
        int gap;
        gap = 0;
        if (idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH)
            while ($urandom_range(0, 99) < (idle_mode == IDLE_SEND ? 83 : 31)) gap++;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= pack_camera(c);
        view_q.push_back(directed_known ? known : build_view(c));
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    function automatic t_camera mk(input int rx, ry, rz, lx, ly, lz, px, py, pz);
        t_camera c;
        c.rgt[0] = rx; c.rgt[1] = ry; c.rgt[2] = rz;
        c.lk[0] = lx;  c.lk[1] = ly;  c.lk[2] = lz;
        c.pos[0] = px; c.pos[1] = py; c.pos[2] = pz;
        return c;
    endfunction

    initial begin
        t_camera dir_tab [$];
        bit      dir_known [$];
        t_view   zero_view, id_view, c;
        t_camera cam;
        int      phase_len;

        for (int i = 0; i < 3; i++) begin
            zero_view.rgt[i] = 0; zero_view.up[i] = 0; zero_view.lk[i] = 0;
            zero_view.shift[i] = 0;
            id_view.rgt[i] = 0; id_view.up[i] = 0; id_view.lk[i] = 0;
        end
        // identity camera: right +x, look +z gives up +y
        id_view.rgt[0] = cvm_pkg::Q_ONE;
        id_view.up[1]  = cvm_pkg::Q_ONE;
        id_view.lk[2]  = cvm_pkg::Q_ONE;
        id_view.shift[0] = -65536; id_view.shift[1] = -131072; id_view.shift[2] = -196608;

        // zero look, zero right, parallel, identity, extremes
        dir_tab.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0)); dir_known.push_back(1);
        dir_tab.push_back(mk(65536, 0, 0, 0, 0, 0, 123, -9, 7)); dir_known.push_back(1);
        dir_tab.push_back(mk(65536, 0, 0, 0, 0, 65536, 65536, 131072, 196608));
        dir_known.push_back(0);
        dir_tab.push_back(mk(0, 0, 0, 0, 65536, 0, 5, 6, 7)); dir_known.push_back(0);
        dir_tab.push_back(mk(65536, 0, 0, 131072, 0, 0, 9, 9, 9)); dir_known.push_back(0);
        dir_tab.push_back(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                             32'h7fffffff, 1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
        dir_known.push_back(0);
        dir_tab.push_back(mk(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                             32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                             32'h80000000)); dir_known.push_back(0);
        dir_tab.push_back(mk(1, -1, 0, 0, 0, 1, 32'h7fffffff, 32'h80000000, 32'h7fffffff));
        dir_known.push_back(0);
        dir_tab.push_back(mk(-1, 0, 0, 0, 1, 0, -1, -1, -1)); dir_known.push_back(0);
        dir_tab.push_back(mk(32'h80000000, 0, 0, 0, 0, 32'h7fffffff, 32'h80000000,
                             32'h80000000, 32'h80000000)); dir_known.push_back(0);
        dir_tab.push_back(mk(0, 32'h7fffffff, 0, 32'h7fffffff, 32'h7fffffff, 0, 0, 0, 0));
        dir_known.push_back(0);
        dir_tab.push_back(mk(65536, 65536, 65536, 1, 2, 3, 32'h40000000, -32'h40000000, 17));
        dir_known.push_back(0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < dir_tab.size(); k++) begin
            c = zero_view;
            if (k == 2) c = id_view;
            send_camera(dir_tab[k], dir_known[k], c);
        end

        for (int ph = 0; ph < 5; ph++) begin
            idle_mode = ph == 0 ? IDLE_NONE : ph == 1 ? IDLE_SEND : ph == 2 ? IDLE_RECV :
                        ph == 3 ? IDLE_BOTH : IDLE_NONE;
            phase_len = ITEM_COUNT / 5;
            for (int n = 0; n < phase_len; n++) begin
                for (int i = 0; i < 3; i++) begin
                    cam.rgt[i] = rand_coord();
                    cam.lk[i]  = rand_coord();
                    cam.pos[i] = rand_coord();
                end
                if ($urandom_range(0, 19) == 0)
                    for (int i = 0; i < 3; i++) cam.lk[i] = 0;
                else if ($urandom_range(0, 19) == 0)
                    for (int i = 0; i < 3; i++) cam.rgt[i] = cam.lk[i];
                send_camera(cam, 0, zero_view);
            end
        end
        i_s_axis_tvalid <= 1'b0;

        while (view_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (mismatch_cnt == 0 && view_q.size() == 0)
            $display("camera_view_matrix_core: match");
        else
            $display("camera_view_matrix_core: mismatch");
        $finish;
    end
endmodule

`default_nettype wire

/* sim.f */
rtl/core/cvm_pkg.sv
rtl/core/cvm_norm.sv
rtl/core/camera_view_matrix_core.sv
rtl/core/cvm_checker.sv
tb/testbench.sv
